// ----- hdl/mlpfe_pkg.sv -----
// ----------------------------------------------------------------------------
// MAVLink 2 position frame encoder package
// Types, frame layout constants and the CRC byte step shared by the encoder.
// ----------------------------------------------------------------------------
package mlpfe_pkg;

  typedef struct packed {
    logic [63:0] timestamp_us;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] z_bits;
    logic [31:0] yaw_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth  = 8;
  localparam logic [CfgIndexWidth-1:0] CFG_SYSTEM_ID    = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CFG_COMPONENT_ID = 1'b1;

  localparam logic [7:0]  FRAME_STX       = 8'hFD;
  localparam logic [7:0]  FRAME_PAYLOAD   = 8'd117;
  localparam logic [23:0] FRAME_MSG_ID    = 24'd102;
  localparam logic [7:0]  FRAME_CRC_EXTRA = 8'd158;
  localparam logic [15:0] FRAME_CRC_INIT  = 16'hFFFF;
  localparam logic [31:0] FRAME_QNAN      = 32'h7FC00000;
  localparam int          FrameCovWords   = 21;

  // Byte positions inside the frame.
  localparam int PosStx       = 0;
  localparam int PosLen       = 1;
  localparam int PosSeq       = 4;
  localparam int PosSysId     = 5;
  localparam int PosCompId    = 6;
  localparam int PosMsgId     = 7;
  localparam int PosTime      = 10;
  localparam int PosAttitude  = 30;
  localparam int PosYaw       = 38;
  localparam int PosCov       = 42;
  localparam int PosReset     = PosCov + 4 * FrameCovWords;
  localparam int PosCrcLow    = PosReset + 1;
  localparam int PosCrcHigh   = PosReset + 2;

  localparam logic [7:0] LAST_BYTE = 8'(PosCrcHigh);

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ acc[7:0];
    t = t ^ (t << 4);
    return (acc >> 8) ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'b0, t[7:4]};
  endfunction

endpackage

// ----- hdl/mavlink2_position_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// MAVLink 2 position frame encoder
// Builds one 129-byte vision position estimate frame per input word and sends
// it as 33 little-endian 32-bit words, one frame byte per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage: an input word (timestamp, x, y, z, yaw) is taken when in_valid is
// high and in_stall is low. in_stall stays high while a frame is being
// serialized, so one frame is built at a time. The serializer walks the
// 129 frame bytes one per cycle, updating the CRC as it goes, and packs
// them into words; a new word follows every four frame bytes, and the last
// word carries one valid byte and last_word. When out_stall holds a word,
// the serializer pauses until the word is taken. The system and component
// ids are to be written through the cfg port only while the block is idle;
// the block itself does not enforce this. Reset clears the sequence number,
// sets both ids to 1 and leaves the block idle with no output word pending.
// ----------------------------------------------------------------------------
module mavlink2_position_frame_encoder (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  mlpfe_pkg::in_t                            in_data,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output mlpfe_pkg::out_t                           out_data,
  input  logic                                      cfg_we,
  input  logic [mlpfe_pkg::CfgIndexWidth-1:0]       cfg_index,
  input  logic [mlpfe_pkg::CfgDataWidth-1:0]        cfg_data
);
  import mlpfe_pkg::*;

  state_t       state;
  state_t       state_next;
  logic [7:0]   byte_idx;
  logic [7:0]   frame_seq;
  logic [7:0]   system_id;
  logic [7:0]   component_id;
  logic [15:0]  crc;
  logic [191:0] data_shift;
  logic [31:0]  word_acc;

  logic         in_accept;
  logic         advance;
  logic [7:0]   cur_byte;
  logic [15:0]  crc_final;
  logic [31:0]  word_cur;
  logic         word_end;
  logic         shift_en;
  logic [1:0]   cov_lane;

  assign in_accept = in_valid && !in_stall;
  assign advance   = (state == ST_RUN) && (!out_valid || !out_stall);
  assign crc_final = crc_step(crc, FRAME_CRC_EXTRA);
  assign cov_lane  = byte_idx[1:0] - 2'(PosCov);
  assign word_end  = (byte_idx[1:0] == 2'd3) || (byte_idx == LAST_BYTE);
  assign shift_en  = ((byte_idx >= 8'(PosTime)) && (byte_idx < 8'(PosAttitude))) ||
                     ((byte_idx >= 8'(PosYaw)) && (byte_idx < 8'(PosCov)));

  always_comb begin
    if (byte_idx == 8'(PosStx)) begin
      cur_byte = FRAME_STX;
    end else if (byte_idx == 8'(PosLen)) begin
      cur_byte = FRAME_PAYLOAD;
    end else if (byte_idx == 8'(PosSeq)) begin
      cur_byte = frame_seq;
    end else if (byte_idx == 8'(PosSysId)) begin
      cur_byte = system_id;
    end else if (byte_idx == 8'(PosCompId)) begin
      cur_byte = component_id;
    end else if (byte_idx == 8'(PosMsgId)) begin
      cur_byte = FRAME_MSG_ID[7:0];
    end else if (byte_idx == 8'(PosMsgId + 1)) begin
      cur_byte = FRAME_MSG_ID[15:8];
    end else if (byte_idx == 8'(PosMsgId + 2)) begin
      cur_byte = FRAME_MSG_ID[23:16];
    end else if (shift_en) begin
      cur_byte = data_shift[7:0];
    end else if ((byte_idx >= 8'(PosCov)) && (byte_idx < 8'(PosReset))) begin
      cur_byte = FRAME_QNAN[8*cov_lane +: 8];
    end else if (byte_idx == 8'(PosCrcLow)) begin
      cur_byte = crc_final[7:0];
    end else if (byte_idx == 8'(PosCrcHigh)) begin
      cur_byte = crc[15:8];
    end else begin
      cur_byte = 8'h00;
    end
  end

  always_comb begin
    if (byte_idx[1:0] == 2'd0) begin
      word_cur = {24'h000000, cur_byte};
    end else begin
      word_cur = word_acc;
      word_cur[8*byte_idx[1:0] +: 8] = cur_byte;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && (byte_idx == LAST_BYTE)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN:  in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      byte_idx     <= 8'd0;
      frame_seq    <= 8'd0;
      system_id    <= 8'd1;
      component_id <= 8'd1;
      crc          <= FRAME_CRC_INIT;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SYSTEM_ID:    system_id    <= cfg_data;
          CFG_COMPONENT_ID: component_id <= cfg_data;
          default: ;
        endcase
      end
      if (advance && word_end) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        crc      <= FRAME_CRC_INIT;
        byte_idx <= 8'd0;
      end else if (advance) begin
        if (byte_idx == LAST_BYTE) begin
          byte_idx  <= 8'd0;
          frame_seq <= frame_seq + 8'd1;
        end else begin
          byte_idx <= byte_idx + 8'd1;
        end
        if (byte_idx == 8'(PosCrcLow)) begin
          crc <= crc_final;
        end else if ((byte_idx != 8'(PosStx)) && (byte_idx < 8'(PosCrcLow))) begin
          crc <= crc_step(crc, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_shift <= {in_data.yaw_bits, in_data.z_bits, in_data.y_bits,
                     in_data.x_bits, in_data.timestamp_us};
    end else if (advance && shift_en) begin
      data_shift <= {8'h00, data_shift[191:8]};
    end
    if (advance) begin
      word_acc <= word_cur;
      if (word_end) begin
        out_data.frame_word  <= word_cur;
        out_data.valid_bytes <= (byte_idx == LAST_BYTE) ? 3'd1 : 3'd4;
        out_data.last_word   <= (byte_idx == LAST_BYTE);
      end
    end
  end

  // A new frame may only start from the first byte position.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (byte_idx == 8'd0))
    else $error("frame accepted while serializer is mid-frame");

  assert property (@(posedge clk) disable iff (rst)
    byte_idx <= LAST_BYTE)
    else $error("byte index beyond end of frame");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (byte_idx == 8'd0))
    else $error("idle serializer left a nonzero byte index");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_word) |-> (out_data.valid_bytes == 3'd1))
    else $error("final word must carry exactly one byte");

  assert property (@(posedge clk) disable iff (rst)
    (advance && (byte_idx == LAST_BYTE)) |=> (state == ST_IDLE) && out_valid)
    else $error("frame end did not release the serializer");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the MAVLink 2 position frame encoder
// A queue-fed driver offers position estimates in random bursts, and a
// monitor checks every frame word against a local frame builder that tracks
// the sequence number, the source ids and the X.25 checksum.
// ----------------------------------------------------------------------------
module tb_top;
  import mlpfe_pkg::*;

  localparam int FrameWords   = 33;
  localparam int PayloadWords = 29;
  localparam int HoldoffLen   = 600;
  localparam int CycleLimit   = 1_500_000;

  typedef enum int {
    RX_EAGER,
    RX_COIN,
    RX_RARE,
    RX_PERIODIC
  } rx_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = CFG_SYSTEM_ID;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  in_t pending_estimates[$];
  out_t expected_words[$];

  logic [7:0] model_sequence = 8'd0;
  logic [7:0] model_system_id = 8'd1;
  logic [7:0] model_component_id = 8'd1;

  int error_count = 0;
  int frames_sent = 0;
  int words_checked = 0;
  int id_settings = 1;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int holdoffs_wanted = 0;
  int holdoffs_done = 0;
  int holdoff_left = 0;
  int rx_mode_left = 0;
  rx_mode_t rx_mode = RX_EAGER;

  mavlink2_position_frame_encoder u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] x25_accumulate(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ acc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

  // Builds the whole frame for one accepted estimate and queues its words.
  task automatic encode_frame_words(input in_t est);
    logic [7:0] frame_bytes[$];
    logic [31:0] body;
    logic [15:0] crc;
    out_t word;
    int i;
    int k;
    frame_bytes = {FRAME_STX, FRAME_PAYLOAD, 8'h00, 8'h00, model_sequence, model_system_id,
                   model_component_id, FRAME_MSG_ID[7:0], FRAME_MSG_ID[15:8],
                   FRAME_MSG_ID[23:16]};
    for (i = 0; i < PayloadWords; i++) begin
      case (i)
        0: body = est.timestamp_us[31:0];
        1: body = est.timestamp_us[63:32];
        2: body = est.x_bits;
        3: body = est.y_bits;
        4: body = est.z_bits;
        5, 6: body = 32'h0;
        7: body = est.yaw_bits;
        default: body = FRAME_QNAN;
      endcase
      for (k = 0; k < 4; k++) frame_bytes = {frame_bytes, body[8*k +: 8]};
    end
    frame_bytes = {frame_bytes, 8'h00};
    crc = FRAME_CRC_INIT;
    for (i = PosLen; i < PosCrcLow; i++) crc = x25_accumulate(crc, frame_bytes[i]);
    crc = x25_accumulate(crc, FRAME_CRC_EXTRA);
    frame_bytes = {frame_bytes, crc[7:0]};
    frame_bytes = {frame_bytes, crc[15:8]};
    while (frame_bytes.size() < 4 * FrameWords) frame_bytes = {frame_bytes, 8'h00};
    for (i = 0; i < FrameWords; i++) begin
      word.frame_word = {frame_bytes[4*i+3], frame_bytes[4*i+2], frame_bytes[4*i+1],
                         frame_bytes[4*i]};
      word.valid_bytes = (i == FrameWords - 1) ? 3'd1 : 3'd4;
      word.last_word = (i == FrameWords - 1);
      expected_words = {expected_words, word};
    end
    model_sequence = model_sequence + 8'd1;
    frames_sent++;
  endtask

  task automatic flag_error(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("Mismatch at %0t: %s got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] pick_float_bits();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0000;
      5: return 32'h7F80_0001;
      6: return 32'h0000_0001;
      7: return 32'h8000_0000;
      8: return 32'h7F7F_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_estimate();
    in_t est;
    if ($urandom_range(0, 9) < 7) begin
      est = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      est.timestamp_us = {pick_float_bits(), pick_float_bits()};
      est.x_bits = pick_float_bits();
      est.y_bits = pick_float_bits();
      est.z_bits = pick_float_bits();
      est.yaw_bits = pick_float_bits();
    end
    return est;
  endfunction

  task automatic queue_estimate(input logic [63:0] t, input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [31:0] yaw);
    in_t est;
    est.timestamp_us = t;
    est.x_bits = x;
    est.y_bits = y;
    est.z_bits = z;
    est.yaw_bits = yaw;
    pending_estimates = {pending_estimates, est};
  endtask

  task automatic wait_drained();
    while (pending_estimates.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ids(input logic [7:0] sys_id, input logic [7:0] comp_id);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SYSTEM_ID;
    cfg_data <= sys_id;
    @(posedge clk);
    cfg_index <= CFG_COMPONENT_ID;
    cfg_data <= comp_id;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_system_id = sys_id;
    model_component_id = comp_id;
    id_settings++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_frame_words(in_data);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_estimates.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_estimates.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        flag_error("word with no frame pending", out_data.frame_word, 32'h0);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_data.frame_word !== want.frame_word)
          flag_error("frame_word", out_data.frame_word, want.frame_word);
        if (out_data.valid_bytes !== want.valid_bytes)
          flag_error("valid_bytes", 32'(out_data.valid_bytes), 32'(want.valid_bytes));
        if (out_data.last_word !== want.last_word)
          flag_error("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
  end

  // Long receiver hold-off, started once a frame is in flight.
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoffs_done < holdoffs_wanted && expected_words.size() != 0) begin
      holdoff_left <= HoldoffLen;
      holdoffs_done <= holdoffs_done + 1;
    end
  end

  always @(posedge clk) begin
    logic stall_now;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(16, 300);
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_EAGER: stall_now = 1'b0;
        RX_COIN: stall_now = 1'($urandom_range(0, 1));
        RX_RARE: stall_now = ($urandom_range(0, 7) == 0);
        default: stall_now = (cycle_count % 11) < 4;
      endcase
      out_stall <= stall_now || (holdoff_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               expected_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_ids[6][2];
    int phase;
    int n;
    phase_ids = '{'{8'h00, 8'h00}, '{8'hFF, 8'hFF}, '{8'h00, 8'hFF}, '{8'hFF, 8'h00},
                  '{8'h5A, 8'hA5}, '{8'h00, 8'h00}};
    phase_ids[5][0] = 8'($urandom);
    phase_ids[5][1] = 8'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed estimates under the reset ids.
    queue_estimate(64'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_estimate('1, '1, '1, '1, '1);
    queue_estimate(64'h0123_4567_89AB_CDEF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                   32'h7F80_0001);
    queue_estimate(64'h1, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h8000_0000);
    queue_estimate(64'h8000_0000_0000_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000,
                   32'h4049_0FDB);
    queue_estimate({16{4'h5}}, {8{4'h5}}, {8{4'hA}}, {8{4'h5}}, {8{4'hA}});
    queue_estimate({16{4'hA}}, {8{4'hA}}, {8{4'h5}}, {8{4'hA}}, {8{4'h5}});
    queue_estimate(64'h7FFF_FFFF_FFFF_FFFF, 32'hFFC0_0000, 32'h8080_0000, 32'h0080_0000,
                   32'hC049_0FDB);
    wait_drained();

    for (phase = 0; phase < 6; phase++) begin
      write_ids(phase_ids[phase][0], phase_ids[phase][1]);
      n = $urandom_range(58, 68);
      repeat (n) pending_estimates = {pending_estimates, random_estimate()};
      if (phase == 1 || phase == 4) holdoffs_wanted++;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d estimates (%0d frame words) over %0d id settings,", frames_sent,
             words_checked, id_settings);
    $display("with the sequence wrapping %0d times and %0d long receiver hold-offs.",
             frames_sent / 256, holdoffs_done);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mlpfe_pkg.sv
hdl/mavlink2_position_frame_encoder.sv
verif/tb_top.sv
